/* rtl/assert_macros.svh */
// Assertion macros shared by the filter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* rtl/wmaf_pkg.sv */
// Package: shared types, constants and compare helpers of the window filter
package wmaf_pkg;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int PIX_W = 24;

  localparam logic [1:0] MODE_CMED = 2'd0;
  localparam logic [1:0] MODE_CAVG = 2'd1;
  localparam logic [1:0] MODE_DAVG = 2'd2;
  localparam logic [1:0] MODE_DMED = 2'd3;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  // one window snapshot handed to the merge stage
  typedef struct packed {
    logic [8:0][PIX_W-1:0] taps;
    logic                  border;
    logic                  last;
    logic [1:0]            mode;
  } win_t;

  // lane results handed to the merge stage
  typedef struct packed {
    logic [2:0][7:0] cres;
    logic [16:0]     dres;
    logic [15:0]     centre;
    logic            border;
    logic            last;
    logic [1:0]      mode;
  } lane_t;

  // compare-exchange on 17-bit signed values: smaller in the low half
  function automatic logic [33:0] cmpx(input logic signed [16:0] a,
                                       input logic signed [16:0] b);
    return (a > b) ? {a, b} : {b, a};
  endfunction
endpackage

/* rtl/window_3x3_median_average_filter_core.sv */
// Top level of the 3x3 median / average window filter
// One word is accepted per clock while no result word waits. Two line RAMs and a
// 3x3 window feed three byte lanes (lane 0 also serves the 16-bit depth plane); a
// merge stage divides, thresholds and packs. A result appears width+1 words after
// its input, then passes the RAM read, window shift, lane sort, merge hold and
// output registers; every stage holds while a result word waits. The sustained
// rate is one word per clock, set by the line RAM read-modify-write, with a bypass
// for one-pixel rows. No clearing pass is needed after reset.
module window_3x3_median_average_filter_core #(
  parameter int MAX_WIDTH  = wmaf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wmaf_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // color_value[23:0], depth_value[39:24]
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // color_result[23:0], depth_result[39:24]
  output logic        m_tlast,   // frame_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wmaf_pkg::*;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int PD = 3;

  logic [1:0]  filter_mode;
  logic [10:0] image_width, image_height;
  logic [15:0] depth_threshold;
  logic        restart;
  logic [1:0]  ridx;

  assign pready = 1'b1;
  assign ridx = paddr[3:2];
  assign restart = psel && penable && pwrite &&
                   (ridx == REG_WIDTH || ridx == REG_HEIGHT);

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= MODE_CMED; image_width <= 11'd1024; image_height <= 11'd1024;
      depth_threshold <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_MODE:   filter_mode <= pwdata[1:0];
        REG_WIDTH:  image_width <= pwdata[10:0];
        REG_HEIGHT: image_height <= pwdata[10:0];
        REG_THRESH: depth_threshold <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (ridx)
      REG_MODE:   prdata = {30'd0, filter_mode};
      REG_WIDTH:  prdata = {21'd0, image_width};
      REG_HEIGHT: prdata = {21'd0, image_height};
      REG_THRESH: prdata = {16'd0, depth_threshold};
      default:    prdata = '0;
    endcase
  end

  // clamp sizes
  logic [CW-1:0] w;
  logic [RW-1:0] h;
  always_comb begin
    if (image_width == 0) w = CW'(1);
    else if (32'(image_width) > MAX_WIDTH) w = CW'(MAX_WIDTH);
    else w = CW'(image_width);
    if (image_height == 0) h = RW'(1);
    else if (32'(image_height) > MAX_HEIGHT) h = RW'(MAX_HEIGHT);
    else h = RW'(image_height);
  end

  // pipeline occupancy: stall all when output stalls
  logic en;
  logic [PD-1:0] vpipe;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  logic acc;
  assign acc = s_tvalid && s_tready;

  logic [CW-1:0] icol, ocol;
  logic [RW-1:0] irow, orow;
  logic tail, step, emit, border, last;
  logic [PIX_W-1:0] entry;
  logic [CW-1:0] c, cn;
  assign tail = irow >= h;
  assign step = acc && (tail || s_tuser == OP_SAMPLE);
  assign entry = tail ? '0 : (filter_mode[1] ? {8'd0, s_tdata[39:24]} : s_tdata[23:0]);
  assign c = (icol >= w) ? '0 : icol;
  assign cn = c + 1'b1;
  assign emit = step && (irow > 1 || (irow == 1 && c >= 1));
  assign border = orow == 0 || orow + 1 >= h || ocol == 0 || ocol + 1 >= w;
  assign last = orow + 1 >= h && ocol + 1 >= w;

  // counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      icol <= '0; irow <= '0; ocol <= '0; orow <= '0;
    end else if (step) begin
      if (emit && last) begin
        icol <= '0; irow <= '0; ocol <= '0; orow <= '0;
      end else begin
        if (cn >= w) begin icol <= '0; irow <= irow + 1'b1; end
        else icol <= cn;
        if (emit) begin
          if (ocol + 1 >= w) begin ocol <= '0; orow <= orow + 1'b1; end
          else ocol <= ocol + 1'b1;
        end
      end
    end
  end

  // line RAMs, read this cycle, data next cycle
  logic [PIX_W-1:0] up_q, mid_q, ent_q;
  logic [AW-1:0] ca;
  assign ca = c[AW-1:0];
  logic step_q, emit_q, border_q, last_q, restart_q;
  logic [AW-1:0] ca_q;
  logic [PIX_W-1:0] mid_fwd, up_fwd;
  logic wr_en;
  logic byp;
  logic [PIX_W-1:0] byp_up, byp_mid;
  assign wr_en = step_q && en;
  wmaf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_up (
    .clk(clk), .we(wr_en), .waddr(ca_q), .wdata(mid_fwd), .re(step), .raddr(ca),
    .rdata(up_q));
  wmaf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid (
    .clk(clk), .we(wr_en), .waddr(ca_q), .wdata(ent_q), .re(step), .raddr(ca),
    .rdata(mid_q));

  // bypass a read that meets the write of the same column on the same edge
  always_ff @(posedge clk) begin
    if (rst) byp <= 1'b0;
    else if (step) byp <= wr_en && (ca == ca_q);
    if (step) begin
      byp_up <= mid_fwd; byp_mid <= ent_q;
    end
  end
  assign up_fwd = byp ? byp_up : up_q;
  assign mid_fwd = byp ? byp_mid : mid_q;

  // hold the accepted word until the window shifts
  always_ff @(posedge clk) begin
    if (rst) begin
      step_q <= 1'b0; emit_q <= 1'b0; restart_q <= 1'b0;
    end else begin
      restart_q <= restart;
      if (en) begin
        step_q <= step; emit_q <= emit;
      end
    end
    if (en) begin
      ent_q <= entry; ca_q <= ca; border_q <= border; last_q <= last;
    end
  end

  // window shift
  logic [8:0][PIX_W-1:0] win;
  always_ff @(posedge clk) begin
    if (rst || restart_q) win <= '0;
    else if (step_q && en) begin
      for (int r = 0; r < 3; r++) begin
        win[3*r] <= win[3*r+1]; win[3*r+1] <= win[3*r+2];
      end
      win[2] <= up_fwd; win[5] <= mid_fwd; win[8] <= ent_q;
    end
  end

  // capture valid, border and last of the window for the lanes after shift
  win_t wv;
  logic wv_valid, wv_border, wv_last;
  always_ff @(posedge clk) begin
    if (rst) wv_valid <= 1'b0;
    else if (en) wv_valid <= emit_q;
    if (en) begin
      wv_border <= border_q; wv_last <= last_q;
    end
  end
  assign wv.taps = win;
  assign wv.border = wv_border;
  assign wv.last = wv_last;
  assign wv.mode = filter_mode;

  // lanes
  logic [2:0][16:0] med;
  logic [2:0][20:0] sum;
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [8:0][16:0] lv;
    always_comb begin
      for (int k = 0; k < 9; k++)
        lv[k] = filter_mode[1] ? (l == 0 ? {win[k][15], win[k][15:0]} : 17'd0)
                               : {9'd0, win[k][8*l +: 8]};
    end
    wmaf_lane u_lane (.clk(clk), .en(en), .v(lv), .med(med[l]), .sum(sum[l]));
  end

  logic [23:0] cres;
  logic [15:0] dres;
  logic        flast;
  wmaf_merge u_merge (.clk(clk), .en(en), .w(wv), .med(med), .sum(sum),
    .thresh(depth_threshold), .cres(cres), .dres(dres), .last(flast));

  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else if (en) vpipe <= {vpipe[PD-2:0], wv_valid};
  end
  assign m_tvalid = vpipe[PD-1];
  assign m_tdata = {dres, cres};
  assign m_tlast = flast;

`include "assert_macros.svh"
  `ASSERT_IMPL(a_col_range, clk, rst, (icol <= w), "input column beyond width")
  `ASSERT_IMPL(a_hold, clk, rst, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped")
  `ASSERT_IMPL(a_emit_step, clk, rst, emit |-> step, "emit without step")
endmodule

/* rtl/wmaf_ram.sv */
// Generic single-write, single-read RAM with registered read
module wmaf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

/* rtl/wmaf_lane.sv */
// One filter lane: median network and plain sum on one 17-bit signed plane
module wmaf_lane (
  input  logic               clk,
  input  logic               en,
  input  logic [8:0][16:0]   v,
  output logic signed [16:0] med,
  output logic signed [20:0] sum
);
  import wmaf_pkg::*;

  logic signed [16:0] s1 [9];
  logic signed [16:0] s2 [9];
  logic signed [20:0] psum;
  logic signed [16:0] t [9];
  logic [33:0] r;

  // first half: sort each row of three, and sum
  always_comb begin
    psum = '0;
    for (int i = 0; i < 9; i++) begin
      t[i] = $signed(v[i]);
      psum = psum + 21'(t[i]);
    end
    for (int g = 0; g < 3; g++) begin
      r = cmpx(t[3*g], t[3*g+1]);
      s1[3*g] = r[16:0]; s1[3*g+1] = r[33:17]; s1[3*g+2] = t[3*g+2];
      r = cmpx(s1[3*g+1], s1[3*g+2]);
      s1[3*g+1] = r[16:0]; s1[3*g+2] = r[33:17];
      r = cmpx(s1[3*g], s1[3*g+1]);
      s1[3*g] = r[16:0]; s1[3*g+1] = r[33:17];
    end
  end

  // hold sorted rows
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) s2[i] <= s1[i];
      sum <= psum;
    end
  end

  // median of row maxima-min, medians-median, minima-max
  logic signed [16:0] mx, md, mn, a, b;
  always_comb begin
    mx = s2[0]; if (s2[3] > mx) mx = s2[3]; if (s2[6] > mx) mx = s2[6];
    mn = s2[2]; if (s2[5] < mn) mn = s2[5]; if (s2[8] < mn) mn = s2[8];
    a = (s2[1] < s2[4]) ? s2[1] : s2[4];
    b = (s2[1] < s2[4]) ? s2[4] : s2[1];
    if (s2[7] < a) md = a; else if (s2[7] > b) md = b; else md = s2[7];
    a = (mx < md) ? mx : md;
    b = (mx < md) ? md : mx;
    if (mn < a) med = a; else if (mn > b) med = b; else med = mn;
  end
endmodule

/* rtl/wmaf_merge.sv */
// Merge stage: divide sums by constants, threshold depth, pack the result
module wmaf_merge (
  input  logic                clk,
  input  logic                en,
  input  wmaf_pkg::win_t      w,
  input  logic [2:0][16:0]    med,
  input  logic [2:0][20:0]    sum,
  input  logic [15:0]         thresh,
  output logic [23:0]         cres,
  output logic [15:0]         dres,
  output logic                last
);
  import wmaf_pkg::*;

  logic [1:0]  mode_q;
  logic        border_q, last_q;
  logic [15:0] centre_q;
  logic [15:0] centre_p;
  logic [1:0]  mode_p;
  logic        border_p, last_p;
  logic [2:0][11:0] csum;
  logic signed [20:0] dsum;
  logic [2:0][7:0] cm;
  logic signed [16:0] dm;

  // align side data with the lane pipeline stage
  always_ff @(posedge clk) begin
    if (en) begin
      mode_p <= w.mode; border_p <= w.border; last_p <= w.last;
      centre_p <= w.taps[4][15:0];
    end
  end

  // hold the nine-tap sums and medians before the reciprocal multiply
  always_ff @(posedge clk) begin
    if (en) begin
      mode_q <= mode_p; border_q <= border_p; last_q <= last_p;
      centre_q <= centre_p;
      dsum <= sum[0];
      dm <= med[0];
      for (int c = 0; c < 3; c++) begin
        csum[c] <= 12'(sum[c]);
        cm[c] <= med[c][7:0];
      end
    end
  end

  // hold the centre bytes for the extra centre weight
  logic [2:0][7:0] cc_p, cc_q;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) cc_p[c] <= w.taps[4][8*c +: 8];
      cc_q <= cc_p;
    end
  end

  logic [2:0][11:0] wsum;
  logic [2:0][7:0]  cavg;
  logic [15:0]      dq_abs;
  logic [20:0]      dabs;
  logic [37:0]      prod;
  logic signed [16:0] davg, dres_c;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      wsum[c] = csum[c] + 12'(3 * cc_q[c]);
      cavg[c] = 8'((24'(wsum[c]) * 24'd2731) >> 15);
    end
    dabs = dsum[20] ? 21'(-dsum) : 21'(dsum);
    prod = 38'(dabs) * 38'd233017;
    dq_abs = 16'(prod >> 21);
    davg = dsum[20] ? -17'(dq_abs) : 17'(dq_abs);
    dres_c = (mode_q == MODE_DAVG) ? davg : dm;
    if (border_q || (dres_c < $signed({thresh[15], thresh}))) dres_c = $signed({centre_q[15], centre_q});
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      last <= last_q;
      if (mode_q[1]) begin
        cres <= '0;
        dres <= dres_c[15:0];
      end else begin
        dres <= '0;
        cres <= border_q ? 24'd0 :
                (mode_q == MODE_CMED ? {cm[2], cm[1], cm[0]} : {cavg[2], cavg[1], cavg[0]});
      end
    end
  end
endmodule

/* tb/window_3x3_median_average_filter_core_test.sv */
// Self-checking testbench for the 3x3 median / average window filter core
`timescale 1ns / 100ps

module window_3x3_median_average_filter_core_test;
  import wmaf_pkg::*;

  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 24;
  localparam int ITEM_TARGET = 1250;

  typedef struct {
    logic        op;
    logic [23:0] color;
    logic [15:0] depth;
  } pixel_word_t;

  typedef struct {
    logic [23:0] color;
    logic [15:0] depth;
    logic        last;
  } filtered_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  window_3x3_median_average_filter_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor copy of configuration and filter state
  logic [1:0]  mode_r;
  logic [10:0] width_r;
  logic [10:0] height_r;
  logic [15:0] thresh_r;
  logic [23:0] upper_line [MAXW];
  logic [23:0] middle_line [MAXW];
  logic [23:0] win [9];
  int unsigned in_col, in_row, out_col, out_row;

  pixel_word_t pending_words[$];
  filtered_t   filtered_q[$];
  pixel_word_t offered;

  int send_idle, recv_stall;
  int hold_requests, holds_done, hold_left;
  int words_sent, results_seen, mismatches, frames_sent, phases_run;
  int quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clamp_dim(input logic [10:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int mid_of_nine(input int v [9]);
    int a [9];
    int i, j, x;
    for (i = 0; i < 9; i++) begin
      x = v[i];
      j = i - 1;
      while (j >= 0 && a[j] > x) begin
        a[j + 1] = a[j];
        j--;
      end
      a[j + 1] = x;
    end
    return a[4];
  endfunction

  function automatic int as_depth(input logic [23:0] e);
    return int'($signed(e[15:0]));
  endfunction

  // Advance the filter state by one accepted word and queue any result
  task automatic filter_word(input pixel_word_t wd);
    int w, h, c, r, k, ch, sum, res, centre;
    int v [9];
    bit depth_mode, tail, emit, border, last;
    logic [23:0] entry, cres;
    filtered_t fr;
    w = clamp_dim(width_r, MAXW);
    h = clamp_dim(height_r, MAXH);
    depth_mode = mode_r >= MODE_DAVG;
    tail = in_row >= h;
    if (!tail && wd.op == OP_DRAIN) return;
    entry = tail ? 24'd0 : (depth_mode ? {8'd0, wd.depth} : wd.color);
    c = in_col;
    if (c >= w) c = 0;
    for (r = 0; r < 3; r++) begin
      win[r * 3] = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = upper_line[c];
    win[5] = middle_line[c];
    win[8] = entry;
    upper_line[c] = middle_line[c];
    middle_line[c] = entry;
    emit = in_row > 1 || (in_row == 1 && c >= 1);
    c++;
    if (c >= w) begin
      c = 0;
      in_row++;
    end
    in_col = c;
    if (!emit) return;
    border = out_row == 0 || out_row + 1 >= h || out_col == 0 || out_col + 1 >= w;
    last = out_row + 1 >= h && out_col + 1 >= w;
    cres = '0;
    fr.depth = '0;
    if (!depth_mode) begin
      if (!border) begin
        for (ch = 0; ch < 3; ch++) begin
          for (k = 0; k < 9; k++) v[k] = (win[k] >> (8 * ch)) & 8'hff;
          if (mode_r == MODE_CMED) begin
            res = mid_of_nine(v);
          end else begin
            sum = 3 * v[4];
            for (k = 0; k < 9; k++) sum += v[k];
            res = sum / 12;
          end
          cres[8 * ch +: 8] = res[7:0];
        end
      end
    end else begin
      centre = as_depth(win[4]);
      res = centre;
      if (!border) begin
        for (k = 0; k < 9; k++) v[k] = as_depth(win[k]);
        if (mode_r == MODE_DAVG) begin
          sum = 0;
          for (k = 0; k < 9; k++) sum += v[k];
          res = sum / 9;
        end else begin
          res = mid_of_nine(v);
        end
        if (res < int'($signed(thresh_r))) res = centre;
      end
      fr.depth = res[15:0];
    end
    fr.color = cres;
    fr.last = last;
    filtered_q.push_back(fr);
    if (last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  // Driver: offer pending words, advance the predictor on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= OP_SAMPLE;
    end else begin
      if (s_tvalid && s_tready) begin
        filter_word(offered);
        words_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
          offered = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {offered.depth, offered.color};
          s_tuser <= offered.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: drive backpressure and compare each result word
  always @(posedge clk) begin
    filtered_t ex;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (filtered_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: data %h last %b", m_tdata, m_tlast);
        end else begin
          ex = filtered_q.pop_front();
          if (m_tdata[23:0] !== ex.color || m_tdata[39:24] !== ex.depth
              || m_tlast !== ex.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: color %h/%h depth %h/%h last %b/%b (exp/act)",
                       ex.color, m_tdata[23:0], ex.depth, m_tdata[39:24], ex.last, m_tlast);
          end
        end
      end
      if (holds_done < hold_requests) begin
        holds_done++;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= $urandom_range(99) >= recv_stall;
      end
    end
  end

  // Watchdog on cycles without any accepted word, result word or register access
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", filtered_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Register write: setup cycle then access cycle
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE:   mode_r = val[1:0];
      REG_WIDTH:  width_r = val[10:0];
      REG_HEIGHT: height_r = val[10:0];
      REG_THRESH: thresh_r = val[15:0];
      default: ;
    endcase
    if (idx == REG_WIDTH || idx == REG_HEIGHT) begin
      for (int k = 0; k < 9; k++) win[k] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    end
  endtask

  // Queue one frame: samples with stray drains, then the tail words
  task automatic queue_frame(input int w, input int h, input bit extremes);
    pixel_word_t wd;
    int n;
    n = 0;
    while (n < w * h) begin
      wd.color = 24'($urandom);
      wd.depth = 16'($urandom);
      wd.op = ($urandom_range(9) == 0) ? OP_DRAIN : OP_SAMPLE;
      if (extremes) begin
        case ($urandom_range(3))
          0: begin wd.color = 24'h000000; wd.depth = 16'h8000; end
          1: begin wd.color = 24'hffffff; wd.depth = 16'h7fff; end
          2: begin wd.color = 24'hff00ff; wd.depth = 16'hffff; end
          default: begin wd.color = 24'h00ff00; wd.depth = 16'h0000; end
        endcase
      end
      if (wd.op == OP_SAMPLE) n++;
      pending_words.push_back(wd);
    end
    for (int k = 0; k < w + 1; k++) begin
      wd.color = 24'($urandom);
      wd.depth = 16'($urandom);
      wd.op = $urandom_range(1) ? OP_DRAIN : OP_SAMPLE;
      pending_words.push_back(wd);
    end
    frames_sent++;
  endtask

  // Hold until every queued word has gone in and every result has come out
  task automatic settle;
    while (pending_words.size() > 0 || s_tvalid || filtered_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [1:0] mode, input logic [10:0] wr, input logic [10:0] hr,
                           input logic [15:0] thr, input int frames, input bit extremes);
    int w, h;
    reg_write(REG_MODE, {30'd0, mode});
    reg_write(REG_WIDTH, {21'd0, wr});
    reg_write(REG_HEIGHT, {21'd0, hr});
    reg_write(REG_THRESH, {16'd0, thr});
    w = clamp_dim(wr, MAXW);
    h = clamp_dim(hr, MAXH);
    for (int f = 0; f < frames; f++) queue_frame(w, h, extremes);
    settle();
    phases_run++;
  endtask

  initial begin
    int idle_sel;
    logic [10:0] wr, hr;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_requests = 0;
    holds_done = 0;
    words_sent = 0;
    results_seen = 0;
    mismatches = 0;
    frames_sent = 0;
    phases_run = 0;
    quiet_cycles = 0;
    mode_r = MODE_CMED;
    width_r = 11'd1024;
    height_r = 11'd1024;
    thresh_r = '0;
    for (int k = 0; k < MAXW; k++) begin
      upper_line[k] = '0;
      middle_line[k] = '0;
    end
    for (int k = 0; k < 9; k++) win[k] = '0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme values in every mode, smallest frames, size clamping
    run_phase(MODE_CMED, 11'd3, 11'd3, 16'h0000, 1, 1'b1);
    run_phase(MODE_CAVG, 11'd3, 11'd3, 16'h0000, 1, 1'b1);
    run_phase(MODE_DAVG, 11'd3, 11'd3, 16'h8000, 1, 1'b1);
    run_phase(MODE_DMED, 11'd3, 11'd3, 16'h7fff, 1, 1'b1);
    run_phase(MODE_CMED, 11'd0, 11'd0, 16'h0000, 2, 1'b0);
    run_phase(MODE_DAVG, 11'd1, 11'd4, 16'h0000, 1, 1'b0);
    run_phase(MODE_DMED, 11'd5, 11'd1, 16'hffff, 1, 1'b0);
    run_phase(MODE_CAVG, 11'd2, 11'd2, 16'h0000, 1, 1'b0);

    // Random phases over the idling patterns, a long receiver hold among them
    while (words_sent < ITEM_TARGET) begin
      idle_sel = phases_run % 4;
      send_idle = (idle_sel == 1) ? 85 : (idle_sel == 3) ? 30 : 0;
      recv_stall = (idle_sel == 2) ? 85 : (idle_sel == 3) ? 30 : 0;
      if (phases_run % 7 == 3) hold_requests++;
      wr = 11'($urandom_range(1, 12));
      hr = 11'($urandom_range(1, 8));
      if ($urandom_range(7) == 0) wr = 11'd0;
      if ($urandom_range(7) == 0) hr = 11'd0;
      case ($urandom_range(3))
        0: run_phase(MODE_DAVG, wr, hr, 16'($urandom), $urandom_range(1, 3), 1'b0);
        1: run_phase(MODE_DMED, wr, hr, $urandom_range(1) ? 16'h8000 : 16'($urandom),
                     $urandom_range(1, 3), 1'b0);
        2: run_phase(MODE_CAVG, wr, hr, 16'($urandom), $urandom_range(1, 3), 1'b0);
        default: run_phase(MODE_CMED, wr, hr, 16'($urandom), $urandom_range(1, 3), 1'b0);
      endcase
    end

    $display("covered %0d phases, %0d frames, %0d input words, %0d result words",
             phases_run, frames_sent, words_sent, results_seen);
    $display("all four modes, small and zero-clamped frame sizes, drains, tail samples, backpressure");
    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, filtered_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
